// File: design/corner_window_nonmax_suppress_core_defines.svh
// Assertion macros for the corner window suppression core.
`ifndef CORNER_WINDOW_NONMAX_SUPPRESS_CORE_DEFINES_SVH
`define CORNER_WINDOW_NONMAX_SUPPRESS_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CWN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CWN_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`else
`define CWN_ASSERT(lbl, prop)
`define CWN_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: design/cwnms_pkg.sv
package cwnms_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;
  localparam int MaxRadiusDef = 16;

  localparam int RespW    = 16;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 2;

  localparam logic [10:0] WidthRst  = 11'd640;
  localparam logic [12:0] HeightRst = 13'd480;
  localparam logic [4:0]  RadiusRst = 5'd12;
  localparam logic [7:0]  ThreshRst = 8'd70;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeFlush = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgRadius = 2'd2,
    CfgThresh = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StScan = 2'd1,
    StLast = 2'd2,
    StEmit = 2'd3
  } state_e;

  typedef struct packed {
    logic             mode;
    logic [RespW-1:0] response;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [11:0] pixel_y;
    logic        is_corner;
    logic        frame_last;
  } out_word_t;

endpackage

// File: design/cwnms_line_mem.sv
module cwnms_line_mem #(
  parameter int Depth = 33 * 1024,
  parameter int AW    = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cwnms_pkg::RespW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [cwnms_pkg::RespW-1:0] rdata_o
);

  logic [cwnms_pkg::RespW-1:0] mem_q [Depth];
  logic [cwnms_pkg::RespW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/corner_window_nonmax_suppress_core.sv
// Corner window non-maximum suppression core.
// Input words (mode, response) arrive on in_valid_i/in_ready_o. A pixel word
// is written into the line store; a flush word only pushes out a pending
// decision. Decisions leave on out_valid_o/out_ready_i, r rows plus r pixels
// behind the input stream, one per pixel once the lag is filled.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only while idle, the core itself does not enforce this.
// A pixel that causes no decision leaves the core idle. A word that causes
// a decision holds off input while the window sequencer reads one in-window
// sample per cycle from the single read port of the line store, so samples
// clipped at the borders cost no read but still one step. The decision lands
// in an output register; the next input word is taken while it waits, and
// the core waits on the output only if a second decision is ready before
// the first was taken. Reset clears positions, lag and configuration to
// defaults; the line store is not cleared and needs no clearing pass.
module corner_window_nonmax_suppress_core #(
  parameter int MaxWidth  = cwnms_pkg::MaxWidthDef,
  parameter int MaxHeight = cwnms_pkg::MaxHeightDef,
  parameter int MaxRadius = cwnms_pkg::MaxRadiusDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cwnms_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cwnms_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cwnms_pkg::in_word_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cwnms_pkg::out_word_t              out_data_o
);

`include "corner_window_nonmax_suppress_core_defines.svh"

  localparam int Slots = 2 * MaxRadius + 1;
  localparam int SW    = $clog2(Slots);
  localparam int SSW   = SW + 2;
  localparam int CW    = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int EW    = CW + 1;
  localparam int HW    = RowW + 1;
  localparam int RW    = $clog2(MaxRadius + 1);
  localparam int DW    = RW + 2;
  localparam int Depth = Slots * MaxWidth;
  localparam int AW    = $clog2(Depth);
  localparam int LW    = $clog2((MaxRadius + 1) * MaxWidth + 2) + 1;
  localparam int PW    = LW + DW + EW + 2;
  localparam int XS    = ((EW > DW) ? EW : DW) + 2;
  localparam int YS    = ((HW > DW) ? HW : DW) + 2;

  // configuration
  logic [10:0] cfg_w_q;
  logic [12:0] cfg_h_q;
  logic [4:0]  cfg_r_q;
  logic [7:0]  cfg_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= cwnms_pkg::WidthRst;
      cfg_h_q <= cwnms_pkg::HeightRst;
      cfg_r_q <= cwnms_pkg::RadiusRst;
      cfg_t_q <= cwnms_pkg::ThreshRst;
    end else if (cfg_we_i) begin
      unique case (cwnms_pkg::cfg_idx_e'(cfg_idx_i))
        cwnms_pkg::CfgWidth:  cfg_w_q <= cfg_wdata_i[10:0];
        cwnms_pkg::CfgHeight: cfg_h_q <= cfg_wdata_i[12:0];
        cwnms_pkg::CfgRadius: cfg_r_q <= cfg_wdata_i[4:0];
        cwnms_pkg::CfgThresh: cfg_t_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [LW-1:0] lag_limit;

  always_comb begin
    if (cfg_w_q == '0) w_eff = EW'(1);
    else if (32'(cfg_w_q) > MaxWidth) w_eff = EW'(MaxWidth);
    else w_eff = EW'(cfg_w_q);
    if (cfg_h_q == '0) h_eff = HW'(1);
    else if (32'(cfg_h_q) > MaxHeight) h_eff = HW'(MaxHeight);
    else h_eff = HW'(cfg_h_q);
    if (32'(cfg_r_q) > MaxRadius) r_eff = RW'(MaxRadius);
    else r_eff = RW'(cfg_r_q);
    lag_limit = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
  end

  // positions, lag and sequencer
  cwnms_pkg::state_e state_q, state_d;
  logic [CW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SW-1:0]   in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [LW-1:0]   lag_q, lag_d;
  logic signed [DW-1:0] dy_q, dy_d, dx_q, dx_d;
  logic            pend_q, pend_d, pend_ctr_q, pend_ctr_d;
  logic            found_q, best_ctr_q;
  logic [cwnms_pkg::RespW-1:0] best_q;
  logic            clr_best;

  logic            out_valid_q, out_load;
  cwnms_pkg::out_word_t out_data_q, out_word;

  logic            in_acc;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [cwnms_pkg::RespW-1:0] mem_rdata;

  logic signed [DW-1:0]  r_s;
  logic signed [XS-1:0]  x_s;
  logic signed [YS-1:0]  y_s;
  logic signed [PW-1:0]  lin;
  logic signed [SSW-1:0] slot_s;
  logic [SW-1:0]         rd_slot;
  logic                  pos_ok, last_pos;

  assign r_s    = $signed({2'b00, r_eff});
  assign in_acc = in_valid_i && in_ready_o;

  // window position under test
  always_comb begin
    x_s = $signed({{(XS-CW){1'b0}}, out_col_q}) + XS'(dx_q);
    y_s = $signed({{(YS-RowW){1'b0}}, out_row_q}) + YS'(dy_q);
    lin = PW'(dy_q) * $signed({{(PW-EW){1'b0}}, w_eff}) + PW'(dx_q);
    pos_ok = (x_s >= 0) && (x_s < $signed({{(XS-EW){1'b0}}, w_eff}))
          && (y_s >= 0) && (y_s < $signed({{(YS-HW){1'b0}}, h_eff}))
          && (lin < $signed({{(PW-LW){1'b0}}, lag_q}));
    slot_s = $signed({2'b00, out_slot_q}) + SSW'(dy_q);
    if (slot_s < 0) slot_s = slot_s + SSW'(Slots);
    else if (slot_s >= SSW'(Slots)) slot_s = slot_s - SSW'(Slots);
    rd_slot   = slot_s[SW-1:0];
    mem_raddr = AW'(rd_slot) * AW'(MaxWidth) + AW'(x_s[CW-1:0]);
    last_pos  = (dx_q == r_s) && (dy_q == r_s);
  end

  assign mem_waddr = AW'(in_slot_q) * AW'(MaxWidth) + AW'(in_col_q);
  assign mem_we    = in_acc && (in_data_i.mode == cwnms_pkg::ModePixel);

  always_comb begin
    out_word.pixel_x    = 10'(out_col_q);
    out_word.pixel_y    = 12'(out_row_q);
    out_word.is_corner  = found_q && best_ctr_q
                          && (best_q[15:8] > cfg_t_q);
    out_word.frame_last = (EW'(out_col_q) == w_eff - EW'(1))
                          && (HW'(out_row_q) == h_eff - HW'(1));
  end

  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    lag_d      = lag_q;
    dy_d       = dy_q;
    dx_d       = dx_q;
    pend_d     = 1'b0;
    pend_ctr_d = 1'b0;
    mem_re     = 1'b0;
    clr_best   = 1'b0;
    out_load   = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cwnms_pkg::StIdle: begin
        in_ready_o = 1'b1;
        dy_d = -r_s;
        dx_d = -r_s;
        if (in_acc) begin
          if (in_data_i.mode == cwnms_pkg::ModeFlush) begin
            if (lag_q != '0) begin
              clr_best = 1'b1;
              state_d  = cwnms_pkg::StScan;
            end
          end else begin
            lag_d = lag_q + LW'(1);
            if (EW'(in_col_q) + EW'(1) >= w_eff) begin
              in_col_d  = '0;
              in_slot_d = (32'(in_slot_q) == Slots - 1) ? '0 : in_slot_q + SW'(1);
              in_row_d  = (HW'(in_row_q) + HW'(1) >= h_eff) ? '0 : in_row_q + RowW'(1);
            end else begin
              in_col_d = in_col_q + CW'(1);
            end
            if (lag_d > lag_limit) begin
              clr_best = 1'b1;
              state_d  = cwnms_pkg::StScan;
            end
          end
        end
      end
      cwnms_pkg::StScan: begin
        // read one in-window sample a cycle; the compare follows in the next cycle
        mem_re     = pos_ok;
        pend_d     = pos_ok;
        pend_ctr_d = (dy_q == '0) && (dx_q == '0);
        if (dx_q == r_s) begin
          dx_d = -r_s;
          dy_d = dy_q + DW'(1);
        end else begin
          dx_d = dx_q + DW'(1);
        end
        if (last_pos) state_d = cwnms_pkg::StLast;
      end
      cwnms_pkg::StLast: begin
        state_d = cwnms_pkg::StEmit;
      end
      cwnms_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          lag_d    = lag_q - LW'(1);
          if (EW'(out_col_q) + EW'(1) >= w_eff) begin
            out_col_d  = '0;
            out_slot_d = (32'(out_slot_q) == Slots - 1) ? '0 : out_slot_q + SW'(1);
            out_row_d  = (HW'(out_row_q) + HW'(1) >= h_eff) ? '0 : out_row_q + RowW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
          state_d = cwnms_pkg::StIdle;
        end
      end
      default: state_d = cwnms_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cwnms_pkg::StIdle;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      lag_q       <= '0;
      dy_q        <= '0;
      dx_q        <= '0;
      pend_q      <= 1'b0;
      pend_ctr_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      lag_q      <= lag_d;
      dy_q       <= dy_d;
      dx_q       <= dx_d;
      pend_q     <= pend_d;
      pend_ctr_q <= pend_ctr_d;
      if (clr_best) begin
        found_q <= 1'b0;
      end else if (pend_q) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // running maximum; strict compare keeps the earliest of equal samples
  always_ff @(posedge clk_i) begin
    if (pend_q && (!found_q || mem_rdata > best_q)) begin
      best_q     <= mem_rdata;
      best_ctr_q <= pend_ctr_q;
    end
    if (out_load) begin
      out_data_q <= out_word;
    end
  end

  // writes happen only while idle and reads only while scanning
  cwnms_line_mem #(
    .Depth (Depth),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_data_i.response),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CWN_ASSERT(a_ready_idle, in_ready_o |-> (state_q == cwnms_pkg::StIdle))
  `CWN_ASSERT_NEVER(a_rw_overlap, mem_we && mem_re)
  `CWN_ASSERT(a_scan_lag, (state_q == cwnms_pkg::StScan) |-> (lag_q != '0))
  `CWN_ASSERT(a_load_free, out_load |-> (!out_valid_q || out_ready_i))

endmodule
